// ===== hw/rtl/rgb_float_to_shared_exponent_macros.svh =====
// Assertion macros shared by the shared-exponent encoder RTL.
`ifndef RGB_FLOAT_TO_SHARED_EXPONENT_MACROS_SVH
`define RGB_FLOAT_TO_SHARED_EXPONENT_MACROS_SVH

// Asserts that an antecedent implies a consequent on the next clock edge.
`define RFSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Asserts that an expression holds at every clock edge outside reset.
`define RFSE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/rfse_pkg.sv =====
// Package with types and constants for the shared-exponent encoder.
`default_nettype none
package rfse_pkg;
    localparam logic [7:0] ExpAllOnes = 8'hFF;
    localparam logic [7:0] BiasedSeven = 8'd134;
    localparam int unsigned SigW = 24;

    typedef struct packed {
        logic [30:0] mag;
        logic        bad;
    } t_chan;

    // Returns the channel's significand with the hidden bit for normal values.
    function automatic logic [SigW-1:0] sig_of(input logic [30:0] mag);
        logic [SigW-1:0] s;
        s = {(mag[30:23] != 8'd0), mag[22:0]};
        return s;
    endfunction

    // Returns the effective biased exponent; denormals count as exponent one.
    function automatic logic [7:0] eff_of(input logic [30:0] mag);
        logic [7:0] e;
        e = (mag[30:23] == 8'd0) ? 8'd1 : mag[30:23];
        return e;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/rfse_scale.sv =====
// Scales one channel significand by a right shift set from the exponent gap.
`default_nettype none
module rfse_scale (
    input  wire logic        i_clk,
    input  wire logic [30:0] i_mag,
    input  wire logic [7:0]  i_emax,
    output logic      [7:0]  o_mant
);
    logic [7:0]  eff;
    logic [8:0]  sh;
    logic [rfse_pkg::SigW-1:0] sig;
    logic [rfse_pkg::SigW-1:0] shifted;
    logic [7:0]  n_mant;

    always_comb begin
        eff = rfse_pkg::eff_of(i_mag);
        sig = rfse_pkg::sig_of(i_mag);
        sh = {1'b0, i_emax} - {1'b0, eff} + 9'd16;
        shifted = sig >> sh[4:0];
        if (i_mag == 31'd0 || eff > i_emax || sh >= 9'd32) begin
            n_mant = 8'd0;
        end else begin
            n_mant = shifted[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_mant <= n_mant;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rgb_float_to_shared_exponent.sv =====
// Shared-exponent encoder: an accepted start passes through r_v[0], r_v[1] and r_v3 to o_valid.
// Throughput: one request per cycle; busy is always low, the three-stage
// pipeline (check/compare, maximum select, shift) sets the latency.
// Receiver cannot stall; each result strobes o_valid for one cycle.
// Synchronous active-low reset clears the valid bits; payload is not reset.
`default_nettype none
`include "rgb_float_to_shared_exponent_macros.svh"
module rgb_float_to_shared_exponent (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_red_bits,
    input  wire logic [31:0] i_green_bits,
    input  wire logic [31:0] i_blue_bits,
    output logic             o_valid,
    output logic [7:0]       o_red_mantissa,
    output logic [7:0]       o_green_mantissa,
    output logic [7:0]       o_blue_mantissa,
    output logic signed [7:0] o_shared_exponent,
    output logic             o_out_of_range
);
    rfse_pkg::t_chan r_c1 [3];
    logic [1:0]  r_v;
    logic        r_gt_rg, r_gt_rb, r_gt_gb;
    logic [30:0] r_mag2 [3];
    logic [7:0]  r_emax2;
    logic        r_bad2, r_zero2, r_tiny2;
    logic        r_flag3;
    logic [7:0]  r_exp3;
    logic        r_v3;
    logic [7:0]  mant [3];
    logic [31:0] in_bits [3];
    logic [30:0] maxmag;
    rfse_pkg::t_chan n_c1 [3];

    assign busy = 1'b0;
    assign in_bits[0] = i_red_bits;
    assign in_bits[1] = i_green_bits;
    assign in_bits[2] = i_blue_bits;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c1[i].mag = in_bits[i][30:0];
            n_c1[i].bad = (in_bits[i][31] && in_bits[i][30:0] != 31'd0)
                || in_bits[i][30:23] == rfse_pkg::ExpAllOnes;
        end
    end

    // Stage 1: register channels and pairwise magnitude compares.
    always_ff @(posedge i_clk) begin
        r_c1 <= n_c1;
        r_gt_rg <= in_bits[0][30:0] >= in_bits[1][30:0];
        r_gt_rb <= in_bits[0][30:0] >= in_bits[2][30:0];
        r_gt_gb <= in_bits[1][30:0] >= in_bits[2][30:0];
    end

    always_comb begin
        if (r_gt_rg && r_gt_rb) begin
            maxmag = r_c1[0].mag;
        end else if (!r_gt_rg && r_gt_gb) begin
            maxmag = r_c1[1].mag;
        end else begin
            maxmag = r_c1[2].mag;
        end
    end

    // Stage 2: maximum exponent and the flag conditions.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mag2[i] <= r_c1[i].mag;
        end
        r_emax2 <= maxmag[30:23];
        r_bad2 <= r_c1[0].bad || r_c1[1].bad || r_c1[2].bad;
        r_zero2 <= maxmag == 31'd0;
        r_tiny2 <= maxmag[30:23] < 8'd7;
    end

    generate
        for (genvar g = 0; g < 3; g++) begin : g_scale
            rfse_scale u_scale (
                .i_clk (i_clk),
                .i_mag (r_mag2[g]),
                .i_emax(r_emax2),
                .o_mant(mant[g])
            );
        end
    endgenerate

    // Stage 3: exponent and flag, alongside the scaled mantissas.
    always_ff @(posedge i_clk) begin
        r_flag3 <= r_bad2 || (!r_zero2 && r_tiny2);
        r_exp3 <= (r_bad2 || r_zero2 || r_tiny2) ? 8'd0 : r_emax2 - rfse_pkg::BiasedSeven;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 2'b00;
            r_v3 <= 1'b0;
        end else begin
            r_v <= {r_v[0], start};
            r_v3 <= r_v[1];
        end
    end

    logic zero_out;
    assign zero_out = r_flag3;
    assign o_valid = r_v3;
    assign o_red_mantissa = r_flag3 ? 8'd0 : mant[0];
    assign o_green_mantissa = r_flag3 ? 8'd0 : mant[1];
    assign o_blue_mantissa = r_flag3 ? 8'd0 : mant[2];
    assign o_shared_exponent = zero_out ? 8'sd0 : $signed(r_exp3);
    assign o_out_of_range = r_flag3;

    `RFSE_ASSERT_NEXT(a_valid_pipe, i_clk, i_rst_n, r_v[1], o_valid)
    `RFSE_ASSERT_ALWAYS(a_flag_zero, i_clk, i_rst_n, !o_out_of_range || o_shared_exponent == 8'sd0)
    `RFSE_ASSERT_ALWAYS(a_busy_low, i_clk, i_rst_n, !busy)
endmodule
`default_nettype wire
